/* rtl/b64e_pkg.sv */
package b64e_pkg;

  // Depth of the group queue between the byte front and the character back
  localparam int QUEUE_DEPTH = 2;

  // Padding character '='
  localparam logic [6:0] PAD_CHAR = 7'h3D;

  // Character slot of the last character in a group
  localparam logic [1:0] LAST_SLOT = 2'd3;

  // One 24-bit group handed from front to back
  typedef struct packed {
    logic [23:0] bits;    // octets, first one in the top bits, zero padded
    logic [1:0]  nbytes;  // real octets in the group, 1..3
    logic        fin;     // group closes the message
  } group_t;

  // Standard alphabet lookup for one 6-bit value
  function automatic logic [6:0] sextet_to_char(input logic [5:0] v);
    logic [6:0] w;
    logic [6:0] c;
    w = {1'b0, v};
    if (v < 6'd26) begin
      c = w + 7'd65;           // 'A'..'Z'
    end else if (v < 6'd52) begin
      c = w + 7'd71;           // 'a'..'z'
    end else if (v < 6'd62) begin
      c = w - 7'd4;            // '0'..'9'
    end else if (v == 6'd62) begin
      c = 7'h2B;               // '+'
    end else begin
      c = 7'h2F;               // '/'
    end
    return c;
  endfunction

endpackage

/* rtl/b64e_front.sv */
module b64e_front
  import b64e_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  input  logic       q_full,
  output logic       push,
  output group_t     push_group
);

  logic [7:0] pend0;
  logic [7:0] pend1;
  logic [1:0] pend_cnt;
  logic       accept;
  logic       emit;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  // a byte closes a group when two are pending or it ends the message
  assign emit     = (pend_cnt == 2'd2) || final_byte;
  assign push     = accept && emit;

  // gather the group, zero padded
  always_comb begin
    push_group.fin    = final_byte;
    push_group.nbytes = pend_cnt + 2'd1;
    case (pend_cnt)
      2'd0:    push_group.bits = {data_byte, 16'h0000};
      2'd1:    push_group.bits = {pend0, data_byte, 8'h00};
      default: push_group.bits = {pend0, pend1, data_byte};
    endcase
  end

  // pending byte store
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_cnt <= 2'd0;
    end else if (accept) begin
      if (emit) begin
        pend_cnt <= 2'd0;
      end else begin
        pend_cnt <= pend_cnt + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !emit) begin
      if (pend_cnt == 2'd0) begin
        pend0 <= data_byte;
      end else begin
        pend1 <= data_byte;
      end
    end
  end

endmodule

/* rtl/b64e_queue.sv */
module b64e_queue
  import b64e_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  group_t push_group,
  input  logic   pop,
  output group_t head,
  output logic   full,
  output logic   empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  group_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_group;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("group queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("group queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("group queue count out of range");

endmodule

/* rtl/b64e_back.sv */
module b64e_back
  import b64e_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  group_t     head,
  input  logic       q_empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] text_char,
  output logic       run_end,
  output logic       message_end
);

  logic [1:0] slot;
  logic       load;
  logic [5:0] sextet;
  logic [6:0] char_next;
  logic       last;

  // output register takes a new character when empty or drained
  assign load = !q_empty && (!out_valid || out_ready);
  assign last = (slot == LAST_SLOT);
  assign pop  = load && last;

  // pick the sextet for this slot
  always_comb begin
    case (slot)
      2'd0:    sextet = head.bits[23:18];
      2'd1:    sextet = head.bits[17:12];
      2'd2:    sextet = head.bits[11:6];
      default: sextet = head.bits[5:0];
    endcase
    // slots past the real octets become padding
    if (slot > head.nbytes) begin
      char_next = PAD_CHAR;
    end else begin
      char_next = sextet_to_char(sextet);
    end
  end

  // slot counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      slot      <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        slot      <= slot + 2'd1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      text_char   <= char_next;
      run_end     <= last;
      message_end <= last && head.fin;
    end
  end

endmodule

/* rtl/base64_stream_encoder.sv */
// Streaming Base64 encoder, standard alphabet with '=' padding.
// Input channel s_*: one message byte per word in s_tdata, s_tlast marks
// the final byte of a message. Output channel m_*: one ASCII character per
// word in m_tdata[6:0]; m_tlast marks the last character of each group of
// four, m_tuser marks the last character of the whole message.
// A byte that neither completes three nor ends the message is held in the
// front and gives no output. A completed or closing group goes into a
// two-entry group queue; the back turns the queue head into four characters,
// one per cycle while m_tready is high, padding short final groups with '='.
// The group taken with the closing byte is written into the queue; once it
// is the queue head and the output register is free, its first character
// is loaded into the output register, and m_tvalid rises.
// Throughput: four characters per group at one character per cycle while
// m_tready is high; the output register sets the limit. The front keeps
// taking bytes until the queue is full.
// Reset clears the pending count, the queue, the slot and the output valid.
// When the receiver stalls, the current character holds, the queue fills
// and then s_tready drops.
module base64_stream_encoder
  import b64e_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // final_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [6:0] text_char, [7] zero
  output logic       m_tlast,   // run_end
  output logic       m_tuser    // message_end
);

  group_t     push_group;
  group_t     head;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_empty;
  logic [6:0] text_char;

  b64e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .data_byte  (s_tdata),
    .final_byte (s_tlast),
    .q_full     (q_full),
    .push       (push),
    .push_group (push_group)
  );

  b64e_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_group (push_group),
    .pop        (pop),
    .head       (head),
    .full       (q_full),
    .empty      (q_empty)
  );

  b64e_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_empty     (q_empty),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .text_char   (text_char),
    .run_end     (m_tlast),
    .message_end (m_tuser)
  );

  assign m_tdata = {1'b0, text_char};

endmodule
